/* sv/rwdd_pkg.sv */
`default_nettype none

package rwdd_pkg;

  // Field widths of the sample word and the configuration port.
  localparam int TIME_W    = 24;
  localparam int COLOR_W   = 8;
  localparam int DROP_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 24;

  // Default geometry of the ring and the windows.
  localparam int DEF_RING_SLOTS   = 36;
  localparam int DEF_WINDOW       = 12;
  localparam int DEF_SLOT_DIVIDER = 4;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_START_TIME      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DROP_PER_SAMPLE = 2'd1;

  // Register reset values.
  localparam logic [TIME_W-1:0] START_TIME_RST      = 24'd3000;
  localparam logic [DROP_W-1:0] DROP_PER_SAMPLE_RST = 8'd10;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // latch the incoming sample word
    logic mul1;       // time times reciprocal of the slot divider
    logic mul2;       // quotient times reciprocal of the ring size
    logic slot_calc;  // remainder gives the ring slot
    logic wr;         // write the ring, set up the read pointer, clear the sum
    logic rd_en;      // read one ring slot
    logic rd_old;     // this read belongs to the oldest window
    logic rd_switch;  // last read of the newest window
    logic fin_load;   // load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic late;       // sample time has reached the start time
  } status_t;

endpackage

`default_nettype wire

/* sv/rwdd_dp.sv */
`default_nettype none

module rwdd_dp #(
  parameter int RING_SLOTS   = rwdd_pkg::DEF_RING_SLOTS,
  parameter int WINDOW       = rwdd_pkg::DEF_WINDOW,
  parameter int SLOT_DIVIDER = rwdd_pkg::DEF_SLOT_DIVIDER
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire rwdd_pkg::cmd_t                 cmd_i,
  output rwdd_pkg::status_t                   status_o,
  input  wire logic [rwdd_pkg::TIME_W-1:0]    time_ms_i,
  input  wire logic [rwdd_pkg::COLOR_W-1:0]   color_i,
  input  wire logic                           cfg_we_i,
  input  wire logic [rwdd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [rwdd_pkg::CFG_DAT_W-1:0] cfg_wdata_i,
  output logic                                finished_o
);

  localparam int TW = rwdd_pkg::TIME_W;
  localparam int CW = rwdd_pkg::COLOR_W;
  localparam int SW = $clog2(RING_SLOTS);
  // Reciprocal constants: exact floor division for any 24-bit dividend.
  localparam int MW  = TW + 2;
  localparam int PW  = TW + MW;
  localparam int S1  = TW + $clog2(SLOT_DIVIDER);
  localparam int S2  = TW + $clog2(RING_SLOTS);
  localparam logic [MW-1:0] M1 = MW'(((64'd1 << S1) / SLOT_DIVIDER) + 64'd1);
  localparam logic [MW-1:0] M2 = MW'(((64'd1 << S2) / RING_SLOTS) + 64'd1);
  // Signed window difference and the unsigned threshold.
  localparam int AW = $clog2(WINDOW * 255 + 1) + 1;
  localparam logic [SW-1:0] LAST_SLOT = SW'(RING_SLOTS - 1);

  logic [TW-1:0]              start_q;
  logic [rwdd_pkg::DROP_W-1:0] drop_q;
  logic [TW-1:0]              time_q;
  logic [CW-1:0]              color_q;
  logic [PW-1:0]              p1_q, p2_q;
  logic [TW-1:0]              quo_q;
  logic [SW-1:0]              slot_q, ptr_q;
  logic                       late_q;
  logic [AW-2:0]              thr_q;
  logic signed [AW-1:0]       acc_q;
  logic [CW-1:0]              ring_q [RING_SLOTS];
  logic [RING_SLOTS-1:0]      vld_q;
  logic [CW-1:0]              rd_data_q;
  logic                       rd_vld_q, rd_en_q, rd_old_q;
  logic                       fin_q;

  logic [TW-1:0]              quo_d, qq_d, slot_d;
  logic [SW-1:0]              slot_inc, ptr_inc, ptr_dec;
  logic signed [AW-1:0]       word_d;

  assign status_o.late = late_q;
  assign finished_o    = fin_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= rwdd_pkg::START_TIME_RST;
      drop_q  <= rwdd_pkg::DROP_PER_SAMPLE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        rwdd_pkg::REG_START_TIME:      start_q <= cfg_wdata_i[TW-1:0];
        rwdd_pkg::REG_DROP_PER_SAMPLE: drop_q  <= cfg_wdata_i[rwdd_pkg::DROP_W-1:0];
        default: ;
      endcase
    end
  end

  // Slot index arithmetic: (time / divider) mod ring size by reciprocals.
  assign quo_d  = TW'(p1_q >> S1);
  assign qq_d   = TW'(p2_q >> S2);
  assign slot_d = quo_q - TW'(qq_d * TW'(RING_SLOTS));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      time_q  <= time_ms_i;
      color_q <= color_i;
    end
    if (cmd_i.mul1) begin
      p1_q   <= PW'(time_q) * PW'(M1);
      late_q <= (time_q >= start_q);
      thr_q  <= (AW-1)'(drop_q) * (AW-1)'(WINDOW);
    end
    if (cmd_i.mul2) begin
      quo_q <= quo_d;
      p2_q  <= PW'(quo_d) * PW'(M2);
    end
    if (cmd_i.slot_calc) begin
      slot_q <= slot_d[SW-1:0];
    end
  end

  // Ring pointer stepping with wrap.
  assign slot_inc = (slot_q == LAST_SLOT) ? '0 : slot_q + SW'(1);
  assign ptr_inc  = (ptr_q == LAST_SLOT) ? '0 : ptr_q + SW'(1);
  assign ptr_dec  = (ptr_q == '0) ? LAST_SLOT : ptr_q - SW'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      ptr_q <= slot_q;
    end else if (cmd_i.rd_en) begin
      priority if (cmd_i.rd_switch) begin
        ptr_q <= slot_inc;
      end else if (cmd_i.rd_old) begin
        ptr_q <= ptr_inc;
      end else begin
        ptr_q <= ptr_dec;
      end
    end
  end

  // Sample ring: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      ring_q[slot_q] <= color_q;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= ring_q[ptr_q];
    end
  end

  // Per-slot valid bits: a slot never written reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      rd_en_q  <= 1'b0;
      rd_old_q <= 1'b0;
    end else begin
      if (cmd_i.wr) begin
        vld_q[slot_q] <= 1'b1;
      end
      if (cmd_i.rd_en) begin
        rd_vld_q <= vld_q[ptr_q];
      end
      rd_en_q  <= cmd_i.rd_en;
      rd_old_q <= cmd_i.rd_old;
    end
  end

  // Running difference: newest slots add, oldest slots subtract.
  assign word_d = rd_vld_q ? $signed({{(AW - CW){1'b0}}, rd_data_q}) : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      acc_q <= '0;
    end else if (rd_en_q) begin
      acc_q <= rd_old_q ? acc_q - word_d : acc_q + word_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.fin_load) begin
      fin_q <= late_q && (acc_q >= $signed({1'b0, thr_q}));
    end
  end

endmodule

`default_nettype wire

/* sv/rwdd_ctrl.sv */
`default_nettype none

module rwdd_ctrl #(
  parameter int WINDOW = rwdd_pkg::DEF_WINDOW
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire rwdd_pkg::status_t status_i,
  output rwdd_pkg::cmd_t         cmd_o
);

  localparam int CNW = $clog2(2 * WINDOW + 1);
  localparam logic [CNW-1:0] RD_LAST  = CNW'(2 * WINDOW);
  localparam logic [CNW-1:0] NEW_LAST = CNW'(WINDOW - 1);
  localparam logic [CNW-1:0] OLD_FRST = CNW'(WINDOW);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_SLOT,
    ST_WRITE,
    ST_SUM,
    ST_CMP
  } state_e;

  state_e         state_q;
  logic [CNW-1:0] cnt_q;
  logic           out_valid_q;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  // Command decode from the current state.
  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.mul1      = (state_q == ST_MUL1);
    cmd_o.mul2      = (state_q == ST_MUL2);
    cmd_o.slot_calc = (state_q == ST_SLOT);
    cmd_o.wr        = (state_q == ST_WRITE);
    cmd_o.rd_en     = (state_q == ST_SUM) && (cnt_q < RD_LAST);
    cmd_o.rd_old    = (cnt_q >= OLD_FRST);
    cmd_o.rd_switch = (cnt_q == NEW_LAST);
    cmd_o.fin_load  = (state_q == ST_CMP) && (!out_valid_q || out_ready_i);
  end

  // Sequencer, read counter and output word valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.fin_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_MUL1;
          end
        end
        ST_MUL1:  state_q <= ST_MUL2;
        ST_MUL2:  state_q <= ST_SLOT;
        ST_SLOT:  state_q <= ST_WRITE;
        ST_WRITE: begin
          cnt_q   <= '0;
          state_q <= status_i.late ? ST_SUM : ST_CMP;
        end
        ST_SUM: begin
          if (cnt_q == RD_LAST) begin
            state_q <= ST_CMP;
          end else begin
            cnt_q <= cnt_q + CNW'(1);
          end
        end
        ST_CMP: begin
          if (!out_valid_q || out_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/ring_window_drop_detector.sv */
// Ring window drop detector. Each accepted sample word writes its color into a
// ring slot chosen by (time_ms / SLOT_DIVIDER) mod RING_SLOTS and returns one
// result word: finished is 1 when time_ms has reached start_time and the sum of
// the newest WINDOW slots (the current one included) exceeds the sum of the
// WINDOW slots after it by at least WINDOW * drop_per_sample. Before start_time
// the window sums are skipped. The next sample is taken once the result word
// is loaded, so it is taken while a result still waits on the output. The work
// per sample is set by the ring's single read port, which visits the 2*WINDOW
// slots one per cycle, after three multiply steps that find the slot. The ring
// reads as all zeros after reset through per-slot valid bits, so there is no
// clearing pass. Configuration must be written by the user only while no sample
// is in flight; the block itself does not enforce it.
`default_nettype none

module ring_window_drop_detector #(
  parameter int RING_SLOTS   = rwdd_pkg::DEF_RING_SLOTS,
  parameter int WINDOW       = rwdd_pkg::DEF_WINDOW,
  parameter int SLOT_DIVIDER = rwdd_pkg::DEF_SLOT_DIVIDER
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [rwdd_pkg::TIME_W-1:0]    time_ms_i,
  input  wire logic [rwdd_pkg::COLOR_W-1:0]   color_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic                                finished_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [rwdd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [rwdd_pkg::CFG_DAT_W-1:0] cfg_wdata_i
);

  rwdd_pkg::cmd_t    cmd;
  rwdd_pkg::status_t status;

  // Sequencer.
  rwdd_ctrl #(
    .WINDOW(WINDOW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Ring, slot arithmetic and window sums.
  rwdd_dp #(
    .RING_SLOTS  (RING_SLOTS),
    .WINDOW      (WINDOW),
    .SLOT_DIVIDER(SLOT_DIVIDER)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .time_ms_i  (time_ms_i),
    .color_i    (color_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .finished_o (finished_o)
  );

  // A sample word in work keeps the input closed.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted again while a sample is in work");

  // A new result word appears only as the sequencer returns to idle.
  a_result_ends_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result word raised while the sequencer is still busy");

  // The ring is written and read never in the same cycle.
  a_no_write_during_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.wr && cmd.rd_en))
    else $error("ring write and read commanded together");

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;

  // Geometry of the block as instantiated.
  localparam int RING_N   = rwdd_pkg::DEF_RING_SLOTS;
  localparam int WIN      = rwdd_pkg::DEF_WINDOW;
  localparam int SLOT_DIV = rwdd_pkg::DEF_SLOT_DIVIDER;

  // Register indexes that the block ignores.
  localparam logic [rwdd_pkg::CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [rwdd_pkg::CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

  localparam int NUM_PHASES   = 8;
  localparam int PHASE_ITEMS  = 200;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int DIR_N        = 18;

  logic                           clk_i;
  logic                           rst_ni      = 1'b0;
  logic                           in_valid    = 1'b0;
  logic                           in_ready_o;
  logic [rwdd_pkg::TIME_W-1:0]    time_ms     = '0;
  logic [rwdd_pkg::COLOR_W-1:0]   color       = '0;
  logic                           out_valid_o;
  logic                           out_ready   = 1'b0;
  logic                           finished_o;
  logic                           cfg_we      = 1'b0;
  logic [rwdd_pkg::CFG_IDX_W-1:0] cfg_index   = '0;
  logic [rwdd_pkg::CFG_DAT_W-1:0] cfg_wdata   = '0;

  // Mirror of the block's ring and registers.
  logic [rwdd_pkg::COLOR_W-1:0] ring_mirror [RING_N];
  logic [rwdd_pkg::TIME_W-1:0]  start_mirror;
  logic [rwdd_pkg::DROP_W-1:0]  drop_mirror;

  // Expected finished flags, oldest first.
  bit finished_q [$];
  int error_count  = 0;
  int results_seen = 0;
  bit tx_burst     = 1'b0;
  bit rx_burst     = 1'b0;

  // One row of the directed part: a register write or a sample word.
  typedef struct packed {
    bit                             is_cfg;
    logic [rwdd_pkg::CFG_IDX_W-1:0] idx;
    logic [rwdd_pkg::CFG_DAT_W-1:0] data;
    logic [rwdd_pkg::TIME_W-1:0]    t;
    logic [rwdd_pkg::COLOR_W-1:0]   c;
    bit                             known;
    bit                             exp;
  } dir_row_t;

  dir_row_t dir_rows [0:DIR_N-1] = '{
    // Before the start time nothing is flagged.
    '{1'b0, rwdd_pkg::REG_START_TIME, 24'd0, 24'd0,        8'd0,   1'b1, 1'b0},
    '{1'b0, rwdd_pkg::REG_START_TIME, 24'd0, 24'd2999,     8'd255, 1'b1, 1'b0},
    // First sample at the start time, then an overwrite of the same slot.
    '{1'b0, rwdd_pkg::REG_START_TIME, 24'd0, 24'd3000,     8'd255, 1'b0, 1'b0},
    '{1'b0, rwdd_pkg::REG_START_TIME, 24'd0, 24'd3003,     8'd0,   1'b0, 1'b0},
    '{1'b0, rwdd_pkg::REG_START_TIME, 24'd0, 24'd3004,     8'd255, 1'b0, 1'b0},
    '{1'b0, rwdd_pkg::REG_START_TIME, 24'd0, 24'hFFFFFF,   8'd255, 1'b0, 1'b0},
    // Largest threshold.
    '{1'b1, rwdd_pkg::REG_DROP_PER_SAMPLE, 24'd255, 24'd0, 8'd0,   1'b0, 1'b0},
    '{1'b0, rwdd_pkg::REG_START_TIME, 24'd0, 24'd3008,     8'd255, 1'b0, 1'b0},
    // Comparison enabled from time zero, then a zero threshold.
    '{1'b1, rwdd_pkg::REG_START_TIME, 24'd0, 24'd0,        8'd0,   1'b0, 1'b0},
    '{1'b0, rwdd_pkg::REG_START_TIME, 24'd0, 24'd0,        8'd128, 1'b0, 1'b0},
    '{1'b1, rwdd_pkg::REG_DROP_PER_SAMPLE, 24'd0, 24'd0,   8'd0,   1'b0, 1'b0},
    '{1'b0, rwdd_pkg::REG_START_TIME, 24'd0, 24'd4,        8'd0,   1'b0, 1'b0},
    // Latest possible start time.
    '{1'b1, rwdd_pkg::REG_START_TIME, 24'hFFFFFF, 24'd0,   8'd0,   1'b0, 1'b0},
    '{1'b0, rwdd_pkg::REG_START_TIME, 24'd0, 24'hFFFFFE,   8'd255, 1'b1, 1'b0},
    '{1'b0, rwdd_pkg::REG_START_TIME, 24'd0, 24'hFFFFFF,   8'd1,   1'b0, 1'b0},
    // Writes to indexes past the last register change nothing.
    '{1'b1, REG_UNUSED_2, 24'h000000, 24'd0,               8'd0,   1'b0, 1'b0},
    '{1'b1, REG_UNUSED_3, 24'hFFFFFF, 24'd0,               8'd0,   1'b0, 1'b0},
    '{1'b0, rwdd_pkg::REG_START_TIME, 24'd0, 24'hFFFFFF,   8'd0,   1'b0, 1'b0}
  };

  ring_window_drop_detector i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .time_ms_i   (time_ms),
    .color_i     (color),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .finished_o  (finished_o),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  // Clock and reset.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Store the sample, then compare the newest window against the oldest one.
  function automatic bit predict_finished(input logic [rwdd_pkg::TIME_W-1:0] t,
                                          input logic [rwdd_pkg::COLOR_W-1:0] c);
    int slot;
    int newest;
    int oldest;
    slot = (int'(t) / SLOT_DIV) % RING_N;
    ring_mirror[slot] = c;
    if (t < start_mirror) return 1'b0;
    newest = 0;
    oldest = 0;
    for (int i = 0; i < WIN; i++) begin
      newest += int'(ring_mirror[(slot + RING_N - (i % RING_N)) % RING_N]);
      oldest += int'(ring_mirror[(slot + i + 1) % RING_N]);
    end
    return (newest - oldest) >= WIN * int'(drop_mirror);
  endfunction

  // Offer one sample word after a random gap and record its expected flag.
  task automatic send_sample(input logic [rwdd_pkg::TIME_W-1:0] t,
                             input logic [rwdd_pkg::COLOR_W-1:0] c,
                             input bit known, input bit known_val);
    int gap;
    bit pred;
    gap = tx_burst ? 0 : $urandom_range(0, 16);
    cfg_we <= 1'b0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    time_ms  <= t;
    color    <= c;
    do @(posedge clk_i); while (!in_ready_o);
    pred = predict_finished(t, c);
    finished_q.push_back(known ? known_val : pred);
  endtask

  // Register write, issued only once every pending result has come back.
  task automatic cfg_write(input logic [rwdd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rwdd_pkg::CFG_DAT_W-1:0] data);
    in_valid <= 1'b0;
    while (finished_q.size() != 0) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    if (idx == rwdd_pkg::REG_START_TIME) begin
      start_mirror = data[rwdd_pkg::TIME_W-1:0];
    end else if (idx == rwdd_pkg::REG_DROP_PER_SAMPLE) begin
      drop_mirror = data[rwdd_pkg::DROP_W-1:0];
    end
  endtask

  // Stimulus: directed table, then phases of sensor traces mixed with noise.
  initial begin : stimulus
    logic [rwdd_pkg::TIME_W-1:0]    trace_t;
    logic [rwdd_pkg::TIME_W-1:0]    t;
    logic [rwdd_pkg::COLOR_W-1:0]   c;
    logic [rwdd_pkg::CFG_DAT_W-1:0] st;
    logic [rwdd_pkg::CFG_DAT_W-1:0] dp;
    int level;
    int lvl;
    int roll;
    for (int i = 0; i < RING_N; i++) ring_mirror[i] = '0;
    start_mirror = rwdd_pkg::START_TIME_RST;
    drop_mirror  = rwdd_pkg::DROP_PER_SAMPLE_RST;
    trace_t = '0;
    level   = 0;
    @(posedge rst_ni);

    for (int r = 0; r < DIR_N; r++) begin
      if (dir_rows[r].is_cfg) begin
        cfg_write(dir_rows[r].idx, dir_rows[r].data);
      end else begin
        send_sample(dir_rows[r].t, dir_rows[r].c, dir_rows[r].known, dir_rows[r].exp);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      trace_t = (ph == 6) ? 24'hFFFE00 : 24'($urandom_range(0, 100000));
      level   = $urandom_range(0, 255);
      case (ph)
        0: begin
          st = 24'd0;
          dp = 24'd10;
        end
        1: begin
          st = 24'd0;
          dp = 24'd0;
        end
        2: begin
          st = 24'hFFFFFF;
          dp = 24'($urandom());
        end
        4: begin
          st = 24'd0;
          dp = 24'd255;
        end
        default: begin
          st = trace_t + 24'($urandom_range(0, 400));
          dp = {16'($urandom()), 8'($urandom_range(0, 20))};
        end
      endcase
      cfg_write(rwdd_pkg::REG_START_TIME, st);
      cfg_write(rwdd_pkg::REG_DROP_PER_SAMPLE, dp);
      cfg_write(REG_UNUSED_2, 24'($urandom()));
      cfg_write(REG_UNUSED_3, 24'($urandom()));
      tx_burst = (ph == 1 || ph == 5);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 19);
        if (roll < 18) begin
          // Sensor trace: time moves on a few ms, level steps now and then.
          trace_t = trace_t + 24'($urandom_range(0, 8));
          if ($urandom_range(0, 39) == 0) level = $urandom_range(0, 255);
          lvl = level + $urandom_range(0, 16) - 8;
          if (lvl < 0) lvl = 0;
          if (lvl > 255) lvl = 255;
          t = trace_t;
          c = 8'(lvl);
        end else if (roll == 18) begin
          // Stray word with arbitrary time and color.
          t = 24'($urandom());
          c = 8'($urandom());
        end else begin
          // Broken trace: time jumps and the trace continues from there.
          trace_t = 24'($urandom());
          t = trace_t;
          c = 8'($urandom());
        end
        send_sample(t, c, 1'b0, 1'b0);
      end
    end

    in_valid <= 1'b0;
    while (finished_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Result side: random ready gaps, one long hold-off, field check per word.
  initial begin : result_sink
    int gap;
    bit want;
    @(posedge rst_ni);
    forever begin
      gap = rx_burst ? 0 : $urandom_range(0, 16);
      if (results_seen == HOLD_AT) gap = HOLD_CYCLES;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if (finished_q.size() == 0) begin
        $error("result word with no prediction pending: finished=%0d", finished_o);
        error_count++;
      end else begin
        want = finished_q.pop_front();
        if (finished_o !== want) begin
          $error("finished mismatch: expected %0d, actual %0d", want, finished_o);
          error_count++;
        end
      end
      results_seen++;
      if (results_seen % 64 == 0) rx_burst = ($urandom_range(0, 3) == 0);
    end
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

/* files.f */
sv/rwdd_pkg.sv
sv/rwdd_dp.sv
sv/rwdd_ctrl.sv
sv/ring_window_drop_detector.sv
tb/tb.sv
